/* sv/qsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types of the three-way quicksort unit: item structs, cell control and states.
// ----------------------------------------------------------------------------
package qsu_pkg;

	localparam int unsigned VALUE_W = 32;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} load_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      end_of_set;
	} result_item_t;

	// Broadcast to every cell of the chain
	typedef struct packed {
		logic                      insert;
		logic                      shift;
		logic signed [VALUE_W-1:0] value;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

endpackage

/* sv/qsu_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_cell
// One slot of the sorted chain: holds a value, takes part in ordered insertion
// and hands its value to the lower neighbor when the chain drains.
// ----------------------------------------------------------------------------
module qsu_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  qsu_pkg::cell_ctl_t                   ctl,
	input  logic                                 prev_lt,
	input  logic signed [qsu_pkg::VALUE_W-1:0]   prev_val,
	input  logic                                 prev_vld,
	input  logic signed [qsu_pkg::VALUE_W-1:0]   next_val,
	input  logic                                 next_vld,
	output logic                                 lt,
	output logic signed [qsu_pkg::VALUE_W-1:0]   val,
	output logic                                 vld
);

	logic signed [qsu_pkg::VALUE_W-1:0] val_q;
	logic                               vld_q;
	logic signed [qsu_pkg::VALUE_W-1:0] val_d;
	logic                               vld_d;

	// An empty slot counts as larger than anything
	assign lt = !vld_q || (ctl.value < val_q);

	always_comb begin
		val_d = val_q;
		vld_d = vld_q;
		if (ctl.shift) begin
			val_d = next_val;
			vld_d = next_vld;
		end else if (ctl.insert && lt) begin
			if (prev_lt) begin
				// make room: take the neighbor's value
				val_d = prev_val;
				vld_d = prev_vld;
			end else begin
				val_d = ctl.value;
				vld_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;
	assign vld = vld_q;

endmodule

/* sv/three_way_quicksort_unit.sv */
`timescale 1ns / 1ps
// Loading: one item per cycle; each value drops into order in the cell chain.
// The item flagged last moves the unit to draining; the first result is ready
// in the cycle after, then one result per cycle while not stalled, N results
// for N of at most MAX_ELEMS elements. No new item is taken while results drain.
// Asynchronous active-low reset empties the chain and returns to loading.
// ----------------------------------------------------------------------------
// three_way_quicksort_unit
// Collects up to MAX_ELEMS signed values and returns them in ascending order.
// ----------------------------------------------------------------------------
module three_way_quicksort_unit #(
	parameter int unsigned MAX_ELEMS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_valid,
	output logic                  load_stall,
	input  qsu_pkg::load_item_t   load,
	output logic                  result_valid,
	input  logic                  result_stall,
	output qsu_pkg::result_item_t result
);

	qsu_pkg::state_t    state_q;
	qsu_pkg::cell_ctl_t ctl;

	logic signed [qsu_pkg::VALUE_W-1:0] cell_val [MAX_ELEMS];
	logic [MAX_ELEMS-1:0]               cell_vld;
	logic [MAX_ELEMS-1:0]               cell_lt;

	logic load_acc;
	logic result_acc;

	assign load_stall   = (state_q == qsu_pkg::ST_EMIT);
	assign result_valid = (state_q == qsu_pkg::ST_EMIT);
	assign load_acc     = load_valid && !load_stall;
	assign result_acc   = result_valid && !result_stall;

	// Drop the value once the chain is full
	assign ctl.insert = load_acc && !cell_vld[MAX_ELEMS-1];
	assign ctl.shift  = result_acc;
	assign ctl.value  = load.value;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ELEMS; gi++) begin : g_cell
			logic                               p_lt;
			logic signed [qsu_pkg::VALUE_W-1:0] p_val;
			logic                               p_vld;
			logic signed [qsu_pkg::VALUE_W-1:0] n_val;
			logic                               n_vld;

			if (gi == 0) begin : g_head
				assign p_lt  = 1'b0;
				assign p_val = '0;
				assign p_vld = 1'b0;
			end else begin : g_mid
				assign p_lt  = cell_lt[gi-1];
				assign p_val = cell_val[gi-1];
				assign p_vld = cell_vld[gi-1];
			end

			if (gi == MAX_ELEMS - 1) begin : g_tail
				assign n_val = '0;
				assign n_vld = 1'b0;
			end else begin : g_body
				assign n_val = cell_val[gi+1];
				assign n_vld = cell_vld[gi+1];
			end

			qsu_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.prev_lt  (p_lt),
				.prev_val (p_val),
				.prev_vld (p_vld),
				.next_val (n_val),
				.next_vld (n_vld),
				.lt       (cell_lt[gi]),
				.val      (cell_val[gi]),
				.vld      (cell_vld[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qsu_pkg::ST_LOAD;
		end else begin
			case (state_q)
				qsu_pkg::ST_LOAD: begin
					if (load_acc && load.last) begin
						state_q <= qsu_pkg::ST_EMIT;
					end
				end
				qsu_pkg::ST_EMIT: begin
					if (result_acc && result.end_of_set) begin
						state_q <= qsu_pkg::ST_LOAD;
					end
				end
				default: begin
					state_q <= qsu_pkg::ST_LOAD;
				end
			endcase
		end
	end

	assign result.sorted_value = cell_val[0];
	assign result.end_of_set   = !cell_vld[1];

`ifndef SYNTHESIS
	// Draining never starts or runs on an empty chain
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == qsu_pkg::ST_EMIT |-> cell_vld[0])
		else $error("draining with empty chain");

	// Occupied cells form a solid run from the head
	assert property (@(posedge clk) disable iff (!arst_n)
		((cell_vld + {{(MAX_ELEMS-1){1'b0}}, 1'b1}) & cell_vld) == '0)
		else $error("gap in cell chain");

	// The final result leaves the chain empty
	assert property (@(posedge clk) disable iff (!arst_n)
		result_acc && result.end_of_set |=> !cell_vld[0])
		else $error("chain not empty after last result");

	generate
		for (gi = 0; gi < MAX_ELEMS - 1; gi++) begin : g_order_chk
			assert property (@(posedge clk) disable iff (!arst_n)
				cell_vld[gi+1] |-> cell_val[gi] <= cell_val[gi+1])
				else $error("chain out of order");
		end
	endgenerate
`endif

endmodule

/* tb/sv/qsu_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_result_checker
// Watches the load and result channels of the quicksort unit, keeps its own
// copy of the set being collected, sorts it when the closing item goes in and
// compares every result item against the oldest pending sorted value.
// ----------------------------------------------------------------------------
module qsu_result_checker #(
	parameter int unsigned MAX_ELEMS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_valid,
	input  logic                  load_stall,
	input  qsu_pkg::load_item_t   load,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  qsu_pkg::result_item_t result,
	output int                    mismatches,
	output int                    pending,
	output int                    sets_closed,
	output int                    results_checked,
	output int                    loads_dropped
);

	logic signed [qsu_pkg::VALUE_W-1:0] held_values[$];
	qsu_pkg::result_item_t              sorted_pending[$];
	qsu_pkg::result_item_t              want;

	initial begin
		mismatches      = 0;
		pending         = 0;
		sets_closed     = 0;
		results_checked = 0;
		loads_dropped   = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns  result check: %s", $time, msg);
		mismatches++;
	endtask

	// Order the collected set ascending and queue one result per element.
	function automatic void queue_sorted_set();
		logic signed [qsu_pkg::VALUE_W-1:0] order[$];
		logic signed [qsu_pkg::VALUE_W-1:0] tmp;
		qsu_pkg::result_item_t              r;
		int                                 j;
		order = held_values;
		for (int i = 1; i < order.size(); i++) begin
			j = i;
			while (j > 0 && order[j-1] > order[j]) begin
				tmp        = order[j-1];
				order[j-1] = order[j];
				order[j]   = tmp;
				j--;
			end
		end
		for (int k = 0; k < order.size(); k++) begin
			r.sorted_value = order[k];
			r.end_of_set   = (k == order.size() - 1);
			sorted_pending.push_back(r);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (load_valid === 1'b1 && load_stall === 1'b0) begin
				// drop anything beyond capacity; the set still closes on last
				if (held_values.size() < MAX_ELEMS)
					held_values.push_back(load.value);
				else
					loads_dropped++;
				if (load.last) begin
					queue_sorted_set();
					held_values.delete();
					sets_closed++;
				end
			end
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				if (sorted_pending.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %0d end %b",
						result.sorted_value, result.end_of_set));
				end else begin
					want = sorted_pending.pop_front();
					results_checked++;
					if (result.sorted_value !== want.sorted_value)
						report_mismatch($sformatf("sorted_value %0d, expected %0d",
							result.sorted_value, want.sorted_value));
					if (result.end_of_set !== want.end_of_set)
						report_mismatch($sformatf("end_of_set %b, expected %b (value %0d)",
							result.end_of_set, want.end_of_set, want.sorted_value));
				end
			end
			pending <= sorted_pending.size();
		end
	end

endmodule

/* tb/sv/tb_three_way_quicksort_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_way_quicksort_unit
// Feeds sets of signed values to the quicksort unit, directed corner sets
// first and then random sets under four idling patterns, and lets the
// result checker verify the ascending output of every set.
// ----------------------------------------------------------------------------
module tb_three_way_quicksort_unit;

	localparam int unsigned MAX_ELEMS    = 64;
	localparam int          CLK_PERIOD   = 8;
	localparam int          RANDOM_ITEMS = 60;
	localparam int          DRAIN_LIMIT  = 20000;
	localparam int          SETTLE       = 16;
	localparam int          RUN_LIMIT_NS = 2000000;

	localparam logic signed [qsu_pkg::VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [qsu_pkg::VALUE_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

	logic                  clk;
	logic                  arst_n;
	logic                  load_valid;
	logic                  load_stall;
	qsu_pkg::load_item_t   load;
	logic                  result_valid;
	logic                  result_stall;
	qsu_pkg::result_item_t result;

	int mismatches;
	int pending;
	int sets_closed;
	int results_checked;
	int loads_dropped;

	int gap_pct;
	int stall_pct;

	// sender idle / receiver stall percentages per phase
	int phase_gap[4]   = '{0, 71, 0, 16};
	int phase_stall[4] = '{0, 0, 71, 16};

	three_way_quicksort_unit #(
		.MAX_ELEMS(MAX_ELEMS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (load_valid),
		.load_stall  (load_stall),
		.load        (load),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	qsu_result_checker #(
		.MAX_ELEMS(MAX_ELEMS)
	) result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.load_valid     (load_valid),
		.load_stall     (load_stall),
		.load           (load),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.mismatches     (mismatches),
		.pending        (pending),
		.sets_closed    (sets_closed),
		.results_checked(results_checked),
		.loads_dropped  (loads_dropped)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout after %0d ns", RUN_LIMIT_NS);
		$display("tb_three_way_quicksort_unit: FAIL");
		$finish;
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// Mix of full-range words, a narrow band that forces duplicates, and extremes.
	function automatic logic signed [qsu_pkg::VALUE_W-1:0] pick_value();
		logic signed [qsu_pkg::VALUE_W-1:0] v;
		case ($urandom_range(3))
			0: v = $signed(32'($urandom_range(8))) - 32'sd4;
			1: begin
				case ($urandom_range(5))
					0: v = MOST_NEG;
					1: v = MOST_POS;
					2: v = MOST_NEG + 32'sd1;
					3: v = MOST_POS - 32'sd1;
					4: v = 32'sd0;
					default: v = -32'sd1;
				endcase
			end
			default: v = $signed($urandom());
		endcase
		return v;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic push_value(input logic signed [qsu_pkg::VALUE_W-1:0] v,
		input logic closes);
		while ($urandom_range(99) < gap_pct) begin
			load_valid <= 1'b0;
			@(negedge clk);
		end
		load_valid <= 1'b1;
		load       <= '{value: v, last: closes};
		do @(posedge clk); while (load_stall !== 1'b0);
		@(negedge clk);
	endtask

	task automatic push_set(input logic signed [qsu_pkg::VALUE_W-1:0] vals[$]);
		for (int k = 0; k < vals.size(); k++)
			push_value(vals[k], k == vals.size() - 1);
	endtask

	initial begin
		int phase_items;
		int set_no;
		int size;
		int waited;
		arst_n     = 1'b0;
		load_valid = 1'b0;
		load       = '0;
		gap_pct    = 0;
		stall_pct  = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-element sets at both extremes
		push_set('{MOST_POS});
		push_set('{MOST_NEG});
		// extremes mixed with repeated values
		push_set('{32'sd5, -32'sd1, MOST_NEG, MOST_POS, 32'sd0, 32'sd5, -32'sd1, 32'sd5});
		// descending, already ascending, all equal
		push_set('{32'sd4, 32'sd3, 32'sd2, 32'sd1});
		push_set('{-32'sd3, 32'sd0, 32'sd3});
		push_set('{32'sd7, 32'sd7, 32'sd7});
		// alternating bit patterns
		push_set('{32'shAAAA_AAAA, 32'sh5555_5555});

		for (int ph = 0; ph < 4; ph++) begin
			gap_pct     = phase_gap[ph];
			stall_pct   = phase_stall[ph];
			phase_items = 0;
			set_no      = 0;
			while (phase_items < RANDOM_ITEMS / 4) begin
				// one set overruns capacity so the tail loads get dropped
				size = (ph == 2 && set_no == 1) ? MAX_ELEMS + 2 : $urandom_range(1, 9);
				for (int k = 0; k < size; k++)
					push_value(pick_value(), k == size - 1);
				phase_items += size;
				set_no++;
			end
		end
		load_valid <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d sets, %0d sorted results checked, %0d loads dropped when full",
			sets_closed, results_checked, loads_dropped);
		$display("idling phases: none, sender idle, receiver stall, both; %0d still pending",
			pending);
		if (mismatches == 0 && pending == 0)
			$display("tb_three_way_quicksort_unit: PASS");
		else
			$display("tb_three_way_quicksort_unit: FAIL");
		$finish;
	end

endmodule
